/* rtl/gbr_pkg.sv */
// Shared constants, pixel types and line buffer control for the 5x5 Gaussian blur.
package gbr_pkg;

  // Line buffer depth: longest row the block can hold
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  localparam int COL_W    = 10;
  localparam int ROW_W    = 12;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int CFG_W    = 12;

  localparam int ROWSUM_W = 14;  // 49 * 255 at most
  localparam int TOTAL_W  = 16;  // 159 * 255 at most
  localparam int PROD_W   = 32;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Floor division by 159 as multiply by ceil(2^23 / 159) and shift
  localparam logic [TOTAL_W-1:0] RECIP_159   = 16'd52759;
  localparam int                 RECIP_SHIFT = 23;

  // Channel 0 is red in the low byte, then green, blue, alpha
  typedef logic [3:0][7:0] pixel_t;
  // Four stored rows of one column, index 0 the oldest
  typedef pixel_t [3:0] lines_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } lb_ctrl_t;

  localparam logic [3:0] GAUSS_W [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

endpackage

/* rtl/gbr_line_buf.sv */
// Four packed line buffers: one word per column holds the four previous rows.
module gbr_line_buf (
  input  logic             clk,
  input  gbr_pkg::lb_ctrl_t ctrl,
  input  gbr_pkg::lines_t  wr_data,
  output gbr_pkg::lines_t  rd_data
);
  import gbr_pkg::*;

  lines_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_addr];
    end
  end

endmodule

/* rtl/gaussian_blur_5x5_rgba.sv */
// Top level of the 5x5 Gaussian blur over a raster RGBA pixel stream.
// Pixels enter in raster order, one word per clock while not stalled, and
// every interior pixel (two or more pixels away from each edge) leaves as one
// word holding the four blurred channels (weights 2..15 summing to 159, result
// floor(sum / 159)), its centre column and row, and tlast on the last interior
// pixel of the frame. Border pixels produce no output word. The block sustains
// one pixel per clock while the output takes words; after the input word that
// completes its window, an output word passes the line buffer read, row sums,
// total, the multiply by the reciprocal of 159 and the output register. Stages
// collapse bubbles, so a stalled output only blocks input once every stage is
// full. The line buffers are a single 1024 x 128 memory with one read and one
// write per cycle; it needs no clearing after reset, since a result never reads
// a row the current frame has not written. Write image_width and image_height
// only while the block is idle; a width outside 5..1024 or a height below 5 is
// clamped.
module gaussian_blur_5x5_rgba (
  input  logic                      clk,
  input  logic                      rst,
  // tdata: in_red, in_green, in_blue, in_alpha (8 bits each) from bit 0 up
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,
  // tdata: out_red, out_green, out_blue, out_alpha (8 bits each),
  //        centre_col (10), centre_row (12), 2 zero bits, from bit 0 up
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata,
  // tlast: frame_last
  output logic                      m_axis_tlast,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0] cfg_data
);
  import gbr_pkg::*;

  // ---------------------------------------------------------------- config
  logic [WIDTH_W-1:0]  width_cfg;
  logic [HEIGHT_W-1:0] height_cfg;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= WIDTH_W'(640);
      height_cfg <= HEIGHT_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_cfg  <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT: height_cfg <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the line buffers and window support
  always_comb begin
    if (width_cfg < WIDTH_W'(5)) begin
      w_eff = WIDTH_W'(5);
    end else if (width_cfg > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_cfg;
    end
    h_eff = (height_cfg < HEIGHT_W'(5)) ? HEIGHT_W'(5) : height_cfg;
  end

  // ------------------------------------------------------- stage handshake
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic move1, move2, move3, move4;
  logic accept;
  logic s1_emit;

  // A stage takes a word when it is empty or its word moves on this cycle
  assign rdy5  = !v5 || m_axis_tready;
  assign move4 = v4 && rdy5;
  assign rdy4  = !v4 || rdy5;
  assign move3 = v3 && rdy4;
  assign rdy3  = !v3 || rdy4;
  assign move2 = v2 && rdy3;
  assign rdy2  = !v2 || rdy3;
  // Border pixels only update buffers and window: never wait downstream
  assign move1 = v1 && (!s1_emit || rdy2);
  assign rdy1  = !v1 || move1;

  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  // --------------------------------------------------- raster position
  logic [COL_W-1:0]   col_count, col_count_next, col_cur;
  logic [ROW_W-1:0]   row_count, row_count_next, row_cur, row_tmp, row_inc;
  logic [WIDTH_W-1:0] col_inc;
  logic               emit_cur, last_cur;

  always_comb begin
    // A width shrunk below the current column ends the row at once
    if ({1'b0, col_count} >= w_eff) begin
      col_cur = '0;
      row_tmp = row_count + 1'b1;
    end else begin
      col_cur = col_count;
      row_tmp = row_count;
    end
    row_cur = (row_tmp >= h_eff) ? '0 : row_tmp;

    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = row_cur + 1'b1;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc;
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = row_cur;
    end

    emit_cur = (col_cur >= COL_W'(4)) && (row_cur >= ROW_W'(4));
    last_cur = ({1'b0, col_cur} == w_eff - 1'b1) && (row_cur == h_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ------------------------------------------- stage 1: line buffer read
  pixel_t           s1_pix;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last;
  lines_t           lb_rd, lb_wr;
  lb_ctrl_t         lb_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= s_axis_tdata;
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_emit <= emit_cur;
      s1_last <= last_cur;
    end
  end

  // Read this column on accept; write back the shifted column as the word
  // leaves stage 1. Consecutive words never share a column.
  always_comb begin
    lb_ctrl.rd_en   = accept;
    lb_ctrl.rd_addr = ADDR_W'(col_cur);
    lb_ctrl.wr_en   = move1;
    lb_ctrl.wr_addr = ADDR_W'(s1_col);
    lb_wr[0]        = lb_rd[1];
    lb_wr[1]        = lb_rd[2];
    lb_wr[2]        = lb_rd[3];
    lb_wr[3]        = s1_pix;
  end

  gbr_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  // ------------------------------------- window shift and stage 2 row sums
  pixel_t              win      [5][5];
  pixel_t              win_next [5][5];
  pixel_t              col_px   [5];
  logic [ROWSUM_W-1:0] rs_next  [5][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_px[k] = lb_rd[k];
    end
    col_px[4] = s1_pix;
    // Shift left by one column and load the new column on the right
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) begin
        win_next[r][c] = win[r][c+1];
      end
      win_next[r][4] = col_px[r];
    end
    for (int r = 0; r < 5; r++) begin
      for (int ch = 0; ch < 4; ch++) begin
        rs_next[r][ch] = '0;
        for (int c = 0; c < 5; c++) begin
          rs_next[r][ch] = rs_next[r][ch]
                         + ROWSUM_W'(GAUSS_W[r][c]) * ROWSUM_W'(win_next[r][c][ch]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      win <= win_next;
    end
  end

  logic [ROWSUM_W-1:0] s2_rs [5][4];
  logic [COL_W-1:0]    s2_col;
  logic [ROW_W-1:0]    s2_row;
  logic                s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= move1 && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && move1 && s1_emit) begin
      s2_rs   <= rs_next;
      s2_col  <= s1_col - COL_W'(2);
      s2_row  <= s1_row - ROW_W'(2);
      s2_last <= s1_last;
    end
  end

  // ------------------------------------------------ stage 3: channel totals
  logic [TOTAL_W-1:0] tot_next [4];
  logic [TOTAL_W-1:0] s3_tot   [4];
  logic [COL_W-1:0]   s3_col;
  logic [ROW_W-1:0]   s3_row;
  logic               s3_last;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      tot_next[ch] = '0;
      for (int r = 0; r < 5; r++) begin
        tot_next[ch] = tot_next[ch] + TOTAL_W'(s2_rs[r][ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= move2;
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      s3_tot  <= tot_next;
      s3_col  <= s2_col;
      s3_row  <= s2_row;
      s3_last <= s2_last;
    end
  end

  // ------------------------------------ stage 4: multiply by 1/159
  logic [PROD_W-1:0] s4_prod [4];
  logic [COL_W-1:0]  s4_col;
  logic [ROW_W-1:0]  s4_row;
  logic              s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= move3;
    end
  end

  always_ff @(posedge clk) begin
    if (move3) begin
      for (int ch = 0; ch < 4; ch++) begin
        s4_prod[ch] <= PROD_W'(s3_tot[ch]) * PROD_W'(RECIP_159);
      end
      s4_col  <= s3_col;
      s4_row  <= s3_row;
      s4_last <= s3_last;
    end
  end

  // --------------------------------------------- stage 5: output register
  pixel_t           s5_px;
  logic [COL_W-1:0] s5_col;
  logic [ROW_W-1:0] s5_row;
  logic             s5_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= move4;
    end
  end

  // The quotient sits in bits above the shift; totals stay below 2^16, so
  // it is exact and fits in 8 bits
  always_ff @(posedge clk) begin
    if (move4) begin
      for (int ch = 0; ch < 4; ch++) begin
        s5_px[ch] <= s4_prod[ch][RECIP_SHIFT +: 8];
      end
      s5_col  <= s4_col;
      s5_row  <= s4_row;
      s5_last <= s4_last;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {2'b00, s5_row, s5_col, s5_px};
  assign m_axis_tlast  = s5_last;

`ifndef SYNTH
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_lb_no_collision: assert property (@(posedge clk) disable iff (rst)
    lb_ctrl.wr_en && lb_ctrl.rd_en |-> lb_ctrl.wr_addr != lb_ctrl.rd_addr)
    else $error("line buffer read and write hit the same column");

  a_border_never_stalls: assert property (@(posedge clk) disable iff (rst)
    v1 && !s1_emit |-> s_axis_tready)
    else $error("border pixel held stage 1");
`endif

endmodule
